// ----- hw/rtl/pnc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_pkg: shared types and constants
// Command and register codes, controller states and the control/status
// bundles between the neighbor counter controller and datapath.
// ----------------------------------------------------------------------------
package pnc_pkg;

    localparam int POS_W     = 32;   // signed Q16.16 coordinate
    localparam int CFG_W     = 31;   // unsigned Q15.16 register
    localparam int CFG_IDX_W = 2;
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 10;
    localparam int COUNT_W   = 10;
    localparam int AXES      = 3;
    localparam int A2_W      = POS_W + 2;      // doubled axis distance
    localparam int SQ_W      = 2 * POS_W;      // square of the low 32 bits
    localparam int SUM_W     = SQ_W + 2;       // sum of three squares
    localparam int WORD_W    = AXES * POS_W;   // stored site word

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CFG_W-1:0]   CUTOFF_RESET = CFG_W'(65536);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_COUNT  = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF = 2'd0,
        CFG_BOX_X  = 2'd1,
        CFG_BOX_Y  = 2'd2,
        CFG_BOX_Z  = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start_query;   // clear the count, take the not-loaded flag
        logic bad;
        logic latch_query;   // take the queried site from the read port
        logic issue_valid;   // word on the read port next cycle is a candidate
        logic load_result;
    } ctl_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } stat_t;

endpackage

// ----- hw/rtl/pnc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pnc_ram #(
    parameter int WIDTH  = 96,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/pnc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_ctrl: command controller
// Decodes commands, keeps the site count, drives the store and sequences
// the neighbor scan through the datapath.
// ----------------------------------------------------------------------------
module pnc_ctrl #(
    parameter int MAX_SITES = 1024,
    parameter int AW        = $clog2(MAX_SITES)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pnc_pkg::CMD_W-1:0]   s_command,
    input  logic [pnc_pkg::IDX_W-1:0]   s_site_index,
    input  pnc_pkg::stat_t              stat,
    output pnc_pkg::ctl_t               ctl,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output logic                        ram_re,
    output logic [AW-1:0]               ram_raddr
);
    import pnc_pkg::*;

    localparam int NW = $clog2(MAX_SITES + 1);

    state_t          state_reg, state_next;
    logic [NW-1:0]   loaded_reg, loaded_next;
    logic [AW-1:0]   scan_reg, scan_next;
    logic [AW-1:0]   query_reg, query_next;
    logic            accept;
    logic            not_loaded;
    logic            last_site;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            loaded_reg <= '0;
        end else begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
        end
        scan_reg  <= scan_next;
        query_reg <= query_next;
    end

    assign accept     = s_valid && s_ready;
    assign not_loaded = 32'(s_site_index) >= 32'(loaded_reg);
    assign last_site  = NW'(scan_reg) == loaded_reg - NW'(1);
    assign ram_waddr  = AW'(loaded_reg);

    always_comb begin
        state_next  = state_reg;
        loaded_next = loaded_reg;
        scan_next   = scan_reg;
        query_next  = query_reg;
        s_ready     = 1'b0;
        ctl         = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = scan_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    unique case (cmd_t'(s_command))
                        CMD_APPEND: begin
                            // a full store drops the site
                            if (32'(loaded_reg) < MAX_SITES) begin
                                ram_we      = 1'b1;
                                loaded_next = loaded_reg + NW'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            loaded_next = '0;
                        end
                        CMD_COUNT: begin
                            ctl.start_query = 1'b1;
                            ctl.bad         = not_loaded;
                            query_next      = AW'(s_site_index);
                            if (not_loaded) begin
                                state_next = ST_DONE;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(s_site_index);
                                state_next = ST_LATCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LATCH: begin
                ctl.latch_query = 1'b1;
                scan_next       = '0;
                state_next      = ST_SCAN;
            end
            ST_SCAN: begin
                ram_re          = 1'b1;
                ctl.issue_valid = scan_reg != query_reg;   // skip the site itself
                if (last_site) begin
                    state_next = ST_DRAIN;
                end else begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    ctl.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/pnc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_datapath: distance pipeline, counter and result register
// Holds the configuration, runs one minimum-image distance test per cycle
// and registers the finished count for the result channel.
// ----------------------------------------------------------------------------
module pnc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pnc_pkg::CFG_W-1:0]     cfg_wdata,
    input  pnc_pkg::ctl_t                 ctl,
    output pnc_pkg::stat_t                stat,
    input  logic [pnc_pkg::WORD_W-1:0]    rd_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pnc_pkg::COUNT_W-1:0]   m_neighbor_count,
    output logic                          m_status
);
    import pnc_pkg::*;

    logic [CFG_W-1:0]            cutoff_reg;
    logic [AXES-1:0][CFG_W-1:0]  box_reg;
    logic [AXES-1:0][A2_W-1:0]   len_reg;
    logic [SQ_W-1:0]             thr_reg;

    logic [AXES-1:0][POS_W-1:0]  query_reg;
    logic [AXES-1:0][POS_W-1:0]  rd_pos;
    logic [AXES-1:0][A2_W-1:0]   a2_reg, a2_next;
    logic [AXES-1:0][A2_W-1:0]   t_reg, t_next;
    logic [AXES-1:0][A2_W-1:0]   m_reg, m_next;
    logic [AXES-1:0][SQ_W-1:0]   sq_reg, sq_next;
    logic [AXES-1:0]             ovf_reg, ovf_next;
    logic [SUM_W-1:0]            sum;
    logic                        hit_reg, hit_next;
    logic                        v_rd_reg, v_a_reg, v_b_reg, v_c_reg, v_d_reg;

    logic [COUNT_W-1:0]          count_reg, count_next;
    logic                        bad_reg;
    logic                        m_valid_reg;
    logic [COUNT_W-1:0]          out_count_reg;
    logic                        out_status_reg;
    logic                        periodic;
    logic [POS_W:0]              c2;

    assign rd_pos   = rd_word;
    assign periodic = box_reg[0] != '0;
    assign c2       = {1'b0, cutoff_reg, 1'b0};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg <= CUTOFF_RESET;
            box_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CUTOFF: cutoff_reg <= cfg_wdata;
                CFG_BOX_X:  box_reg[0] <= cfg_wdata;
                CFG_BOX_Y:  box_reg[1] <= cfg_wdata;
                CFG_BOX_Z:  box_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // derived constants, settled long before a query starts
    always_ff @(posedge aclk) begin
        for (int i = 0; i < AXES; i++) begin
            len_reg[i] <= periodic ? A2_W'(box_reg[i]) : '0;
        end
        thr_reg <= SQ_W'(c2[POS_W-1:0]) * SQ_W'(c2[POS_W-1:0]);
    end

    // stage a: doubled absolute difference
    always_comb begin
        logic signed [POS_W:0] d;
        logic [POS_W:0]        ad;
        d  = '0;
        ad = '0;
        for (int i = 0; i < AXES; i++) begin
            d  = $signed({query_reg[i][POS_W-1], query_reg[i]})
               - $signed({rd_pos[i][POS_W-1], rd_pos[i]});
            ad = d[POS_W] ? $unsigned(-d) : $unsigned(d);
            a2_next[i] = {ad, 1'b0};
        end
    end

    // stages b and c: minimum image, |L - |L - 2|d|||; a zero length passes through
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            t_next[i] = (len_reg[i] >= a2_reg[i]) ? len_reg[i] - a2_reg[i]
                                                  : a2_reg[i] - len_reg[i];
            m_next[i] = (len_reg[i] >= t_reg[i]) ? len_reg[i] - t_reg[i]
                                                 : t_reg[i] - len_reg[i];
        end
    end

    // stage d: squares, anything at or above 2^32 can never be a neighbor
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            ovf_next[i] = m_reg[i][A2_W-1:POS_W] != '0;
            sq_next[i]  = SQ_W'(m_reg[i][POS_W-1:0]) * SQ_W'(m_reg[i][POS_W-1:0]);
        end
    end

    // stage e: sum and threshold compare
    assign sum      = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    assign hit_next = v_d_reg && !(|ovf_reg) && (sum < SUM_W'(thr_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_rd_reg <= 1'b0;
            v_a_reg  <= 1'b0;
            v_b_reg  <= 1'b0;
            v_c_reg  <= 1'b0;
            v_d_reg  <= 1'b0;
            hit_reg  <= 1'b0;
        end else begin
            v_rd_reg <= ctl.issue_valid;
            v_a_reg  <= v_rd_reg;
            v_b_reg  <= v_a_reg;
            v_c_reg  <= v_b_reg;
            v_d_reg  <= v_c_reg;
            hit_reg  <= hit_next;
        end
        if (ctl.latch_query) begin
            query_reg <= rd_pos;
        end
        a2_reg  <= a2_next;
        t_reg   <= t_next;
        m_reg   <= m_next;
        sq_reg  <= sq_next;
        ovf_reg <= ovf_next;
    end

    // neighbor count, saturating
    always_comb begin
        count_next = count_reg;
        if (ctl.start_query) begin
            count_next = '0;
        end else if (hit_reg && count_reg != COUNT_MAX) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        if (ctl.start_query) begin
            bad_reg <= ctl.bad;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (ctl.load_result) begin
            out_count_reg  <= bad_reg ? '0 : count_reg;
            out_status_reg <= bad_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_neighbor_count = out_count_reg;
    assign m_status         = out_status_reg;

    assign stat.pipe_busy = v_rd_reg | v_a_reg | v_b_reg | v_c_reg | v_d_reg | hit_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

// ----- hw/rtl/periodic_neighbor_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_neighbor_counter: cutoff neighbor count with minimum image
// Append, clear and count commands over a store of Q16.16 site positions.
// Append and clear finish on acceptance; a word is accepted every cycle
//   while no count is in progress. Count of a loaded site: latch the site,
//   scan the N stored sites, one stored site per cycle from the store's single
//   read port, drain the pipeline and load the result. A not-loaded index skips the scan.
// The next word is accepted while a result waits in the output register.
// Reset clears the site count and sets the registers to their reset values;
//   the store itself is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module periodic_neighbor_counter #(
    parameter int MAX_SITES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pnc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pnc_pkg::CMD_W-1:0]     s_command,
    input  logic signed [pnc_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [pnc_pkg::POS_W-1:0] s_pos_y,
    input  logic signed [pnc_pkg::POS_W-1:0] s_pos_z,
    input  logic [pnc_pkg::IDX_W-1:0]     s_site_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pnc_pkg::COUNT_W-1:0]   m_neighbor_count,
    output logic                          m_status
);
    import pnc_pkg::*;

    localparam int AW = $clog2(MAX_SITES);

    ctl_t              ctl;
    stat_t             stat;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    // z in the top word so axis i sits at slice i
    assign ram_wdata = {s_pos_z, s_pos_y, s_pos_x};

    pnc_ctrl #(
        .MAX_SITES (MAX_SITES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_site_index (s_site_index),
        .stat         (stat),
        .ctl          (ctl),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr)
    );

    pnc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SITES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pnc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .ctl              (ctl),
        .stat             (stat),
        .rd_word          (ram_rdata),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbor_count (m_neighbor_count),
        .m_status         (m_status)
    );

endmodule

// ----- test/pnc_neighbor_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnc_neighbor_checker: count predictor and result comparison
// Watches the register port and both handshake channels of the neighbor
// counter. It keeps its own site store and registers, works out each count
// when the count word is accepted, and compares the results in order.
// ----------------------------------------------------------------------------
module pnc_neighbor_checker #(
    parameter int SITE_CAP = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pnc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pnc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [pnc_pkg::CMD_W-1:0]     s_command,
    input  logic [pnc_pkg::POS_W-1:0]     s_pos_x,
    input  logic [pnc_pkg::POS_W-1:0]     s_pos_y,
    input  logic [pnc_pkg::POS_W-1:0]     s_pos_z,
    input  logic [pnc_pkg::IDX_W-1:0]     s_site_index,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [pnc_pkg::COUNT_W-1:0]   m_neighbor_count,
    input  logic                          m_status,
    output int                            pending,
    output int                            fail_count,
    output int                            results_checked
);
    import pnc_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] neighbor_count;
        logic               status;
    } count_word_t;

    logic [POS_W-1:0] site_x [SITE_CAP];
    logic [POS_W-1:0] site_y [SITE_CAP];
    logic [POS_W-1:0] site_z [SITE_CAP];
    int unsigned      n_sites = 0;

    logic [CFG_W-1:0] cutoff_q16 = CUTOFF_RESET;
    logic [CFG_W-1:0] box_x_q16 = '0;
    logic [CFG_W-1:0] box_y_q16 = '0;
    logic [CFG_W-1:0] box_z_q16 = '0;

    count_word_t expected_counts [$];
    count_word_t exp_word;
    int          n_fail = 0;
    int          n_checked = 0;

    // doubled axis distance, folded to the nearest image when wrap is set
    function automatic logic [A2_W-1:0] span2(logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                                              logic wrap, logic [CFG_W-1:0] len);
        logic signed [POS_W:0] diff;
        logic [POS_W:0]        mag;
        logic [A2_W-1:0]       twice;
        logic [A2_W-1:0]       l2;
        logic [A2_W-1:0]       t;
        diff = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
        mag = diff[POS_W] ? -diff : diff;
        twice = {mag, 1'b0};
        if (wrap) begin
            l2 = A2_W'(len);
            t = (l2 >= twice) ? l2 - twice : twice - l2;
            twice = (l2 >= t) ? l2 - t : t - l2;
        end
        return twice;
    endfunction

    // saturating sum of squares; a term of 2^32 or more can never pass the cutoff
    function automatic logic [SQ_W-1:0] add_square(logic [SQ_W-1:0] acc, logic [A2_W-1:0] m);
        logic [SQ_W:0] total;
        if (m[A2_W-1:32] != '0)
            return '1;
        total = {1'b0, acc} + {33'd0, m[31:0]} * {33'd0, m[31:0]};
        return total[SQ_W] ? '1 : total[SQ_W-1:0];
    endfunction

    function automatic count_word_t predict_count(logic [IDX_W-1:0] idx);
        count_word_t      res;
        logic             wrap;
        logic [31:0]      c2;
        logic [SQ_W-1:0]  thr;
        logic [SQ_W-1:0]  dist2;
        int unsigned      hits;
        res = '0;
        if (idx >= n_sites) begin
            res.status = 1'b1;
            return res;
        end
        wrap = (box_x_q16 != '0);
        c2 = {cutoff_q16, 1'b0};
        thr = {32'd0, c2} * {32'd0, c2};
        hits = 0;
        for (int j = 0; j < n_sites; j++) begin
            if (j != idx) begin
                dist2 = add_square('0, span2(site_x[idx], site_x[j], wrap, box_x_q16));
                dist2 = add_square(dist2, span2(site_y[idx], site_y[j], wrap, box_y_q16));
                dist2 = add_square(dist2, span2(site_z[idx], site_z[j], wrap, box_z_q16));
                if (dist2 < thr && hits < COUNT_MAX)
                    hits++;
            end
        end
        res.neighbor_count = COUNT_W'(hits);
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_q16 = CUTOFF_RESET;
            box_x_q16 = '0;
            box_y_q16 = '0;
            box_z_q16 = '0;
            n_sites = 0;
            expected_counts.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CUTOFF: cutoff_q16 = cfg_wdata;
                    CFG_BOX_X:  box_x_q16 = cfg_wdata;
                    CFG_BOX_Y:  box_y_q16 = cfg_wdata;
                    default:    box_z_q16 = cfg_wdata;
                endcase
            end

            if (m_valid && m_ready) begin
                if (expected_counts.size() == 0) begin
                    n_fail++;
                    $display("%0t: result with nothing expected, expected none, got count %0d status %0d",
                             $time, m_neighbor_count, m_status);
                end else begin
                    exp_word = expected_counts.pop_front();
                    n_checked++;
                    if (m_neighbor_count !== exp_word.neighbor_count) begin
                        n_fail++;
                        $display("%0t: neighbor_count expected %0d, got %0d",
                                 $time, exp_word.neighbor_count, m_neighbor_count);
                    end
                    if (m_status !== exp_word.status) begin
                        n_fail++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, exp_word.status, m_status);
                    end
                end
            end

            if (s_valid && s_ready) begin
                case (s_command)
                    CMD_APPEND: begin
                        // a full store drops the word
                        if (n_sites < SITE_CAP) begin
                            site_x[n_sites] = s_pos_x;
                            site_y[n_sites] = s_pos_y;
                            site_z[n_sites] = s_pos_z;
                            n_sites++;
                        end
                    end
                    CMD_COUNT: expected_counts.push_back(predict_count(s_site_index));
                    CMD_CLEAR: n_sites = 0;
                    default: ;
                endcase
            end
        end
        pending <= expected_counts.size();
        fail_count <= n_fail;
        results_checked <= n_checked;
    end

endmodule

// ----- test/periodic_neighbor_counter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_neighbor_counter_tb: neighbor counter testbench top
// Drives append, count, clear and unused command words in random bursts,
// with the result side stalling on its own pattern. A directed opening hits
// the edge cases, then random phases run over several cutoff and box
// settings.
// ----------------------------------------------------------------------------
module periodic_neighbor_counter_tb;
    import pnc_pkg::*;

    localparam int SITE_CAP      = 1024;
    localparam int ONE           = 65536;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_WORDS   = 66;
    localparam int STORE_SOFT_CAP = 48;
    localparam int N_PHASES      = 8;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;
    localparam logic [CFG_W-1:0] CFG_MAX = '1;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command;
    logic signed [POS_W-1:0] s_pos_x;
    logic signed [POS_W-1:0] s_pos_y;
    logic signed [POS_W-1:0] s_pos_z;
    logic [IDX_W-1:0]      s_site_index;
    logic                  m_valid;
    logic                  m_ready;
    logic [COUNT_W-1:0]    m_neighbor_count;
    logic                  m_status;

    int pending;
    int fail_count;
    int results_checked;

    int cycle_count = 0;
    int words_sent = 0;
    int settings_used = 0;
    int sites_held = 0;
    int burst_left = 0;
    int rdy_mode = 0;
    int rdy_timer = 0;
    int rdy_hold = 0;

    periodic_neighbor_counter #(
        .MAX_SITES(SITE_CAP)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_site_index     (s_site_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbor_count (m_neighbor_count),
        .m_status         (m_status)
    );

    pnc_neighbor_checker #(
        .SITE_CAP(SITE_CAP)
    ) i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_pos_z          (s_pos_z),
        .s_site_index     (s_site_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbor_count (m_neighbor_count),
        .m_status         (m_status),
        .pending          (pending),
        .fail_count       (fail_count),
        .results_checked  (results_checked)
    );

    always #2 aclk = ~aclk;

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("FAIL periodic_neighbor_counter");
        $finish;
    end

    // result side: the ready mode is redrawn whenever its random timer runs out
    always @(posedge aclk) begin
        if (rdy_timer == 0) begin
            rdy_mode = $urandom_range(3);
            rdy_timer = $urandom_range(50, 300);
        end else begin
            rdy_timer--;
        end
        case (rdy_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(1));
            2: begin
                if (rdy_hold != 0) begin
                    rdy_hold--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(15) == 0) begin
                    rdy_hold = $urandom_range(40);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
            default: m_ready <= (rdy_timer % 4 == 0);
        endcase
    end

    task automatic send_word(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [POS_W-1:0] z, logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_pos_x      <= x;
        s_pos_y      <= y;
        s_pos_z      <= z;
        s_site_index <= idx;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic append_site(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
        send_word(CMD_APPEND, x, y, z, IDX_W'($urandom));
        if (sites_held < SITE_CAP)
            sites_held++;
    endtask

    task automatic count_site(logic [IDX_W-1:0] idx);
        send_word(CMD_COUNT, $urandom, $urandom, $urandom, idx);
    endtask

    task automatic clear_store();
        send_word(CMD_CLEAR, $urandom, $urandom, $urandom, IDX_W'($urandom));
        sites_held = 0;
    endtask

    // mostly loaded sites, sometimes just past the end or anywhere
    task automatic count_random_site();
        logic [IDX_W-1:0] idx;
        if (sites_held > 0 && $urandom_range(7) != 0) begin
            idx = IDX_W'($urandom_range(sites_held - 1));
        end else begin
            case ($urandom_range(2))
                0: idx = IDX_W'(sites_held);
                1: idx = '1;
                default: idx = IDX_W'($urandom);
            endcase
        end
        count_site(idx);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic set_regs(logic [CFG_W-1:0] cut, logic [CFG_W-1:0] bx,
                            logic [CFG_W-1:0] by, logic [CFG_W-1:0] bz);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_CUTOFF;
        cfg_wdata <= cut;
        @(posedge aclk);
        cfg_index <= CFG_BOX_X;
        cfg_wdata <= bx;
        @(posedge aclk);
        cfg_index <= CFG_BOX_Y;
        cfg_wdata <= by;
        @(posedge aclk);
        cfg_index <= CFG_BOX_Z;
        cfg_wdata <= bz;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    // zero spread means anywhere in the full coordinate range
    function automatic logic [POS_W-1:0] scatter(int spread);
        int off;
        if (spread == 0)
            return $urandom;
        off = $urandom_range(2 * spread);
        return off - spread;
    endfunction

    initial begin : stimulus
        logic [CFG_W-1:0] cut, bx, by, bz;
        int spread;
        int words;
        int pick;

        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= CFG_CUTOFF;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_command    <= CMD_APPEND;
        s_pos_x      <= '0;
        s_pos_y      <= '0;
        s_pos_z      <= '0;
        s_site_index <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset settings: cutoff 1.0, open boundaries
        count_site('0);
        send_word(CMD_UNUSED, '1, '1, '1, '1);
        append_site(0, 0, 0);
        append_site(0, 0, 0);
        append_site(ONE / 2, 0, 0);
        append_site(ONE, 0, 0);
        append_site(POS_MAX, POS_MAX, POS_MAX);
        append_site(POS_MIN, POS_MIN, POS_MIN);
        count_site(IDX_W'(0));
        count_site(IDX_W'(2));
        count_site(IDX_W'(3));
        count_site(IDX_W'(4));
        count_site(IDX_W'(5));
        count_site(IDX_W'(6));
        count_site('1);
        send_word(CMD_UNUSED, '0, '0, '0, '0);
        count_site(IDX_W'(0));
        clear_store();
        count_site(IDX_W'(0));
        append_site(-ONE, ONE, -ONE);
        count_site(IDX_W'(0));

        // zero cutoff: a coincident site is not a neighbor
        set_regs('0, '0, '0, '0);
        append_site(-ONE, ONE, -ONE);
        count_site(IDX_W'(0));
        count_site(IDX_W'(1));

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin
                    cut = CFG_W'(ONE); bx = '0; by = '0; bz = '0; spread = 3 * ONE / 2;
                end
                1: begin
                    cut = CFG_W'(5 * ONE / 2); bx = CFG_W'(10 * ONE);
                    by = CFG_W'(10 * ONE); bz = CFG_W'(10 * ONE);
                    spread = 10 * ONE;
                end
                2: begin
                    // only x sets the wrap; y and z fold with a zero length
                    cut = CFG_W'(3 * ONE); bx = CFG_W'(8 * ONE); by = '0; bz = '0;
                    spread = 4 * ONE;
                end
                3: begin
                    cut = CFG_MAX; bx = CFG_MAX; by = CFG_MAX; bz = CFG_MAX; spread = 0;
                end
                4: begin
                    cut = CFG_MAX; bx = '0; by = '0; bz = '0; spread = 0;
                end
                5: begin
                    cut = CFG_W'(1); bx = '0; by = '0; bz = '0; spread = 1;
                end
                6: begin
                    cut = CFG_W'(3 * ONE / 2); bx = CFG_W'(3 * ONE);
                    by = CFG_W'(5 * ONE); bz = CFG_W'(7 * ONE);
                    spread = 20 * ONE;
                end
                default: begin
                    cut = '0; bx = CFG_W'(6 * ONE); by = CFG_W'(6 * ONE);
                    bz = CFG_W'(6 * ONE); spread = ONE;
                end
            endcase
            set_regs(cut, bx, by, bz);
            clear_store();
            words = 0;
            while (words < PHASE_WORDS) begin
                pick = $urandom_range(99);
                if (pick < 3) begin
                    send_word(CMD_UNUSED, $urandom, $urandom, $urandom, IDX_W'($urandom));
                end else begin
                    words++;
                    if (pick < 6)
                        clear_store();
                    else if (pick < 10)
                        append_site($urandom, $urandom, $urandom);
                    else if (pick < 52 && sites_held < STORE_SOFT_CAP)
                        append_site(scatter(spread), scatter(spread), scatter(spread));
                    else
                        count_random_site();
                end
            end
        end

        settle();
        $display("sent %0d command words over %0d register settings, checked %0d counts",
                 words_sent, settings_used, results_checked);
        $display("store cleared and refilled per phase, open and periodic, cutoff zero to max");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS periodic_neighbor_counter");
        end else begin
            $display("FAIL periodic_neighbor_counter");
        end
        $finish;
    end

endmodule
